### src/mavg_pkg.sv
package mavg_pkg;

  // Port widths fixed by the interface
  localparam int unsigned SampleW = 16;
  localparam int unsigned OutW    = 24;

  // Fractional bits of the result
  localparam int unsigned FracBits = 8;

  // Parameter defaults
  localparam int unsigned DefWindow     = 5;
  localparam int unsigned DefSampleBits = 16;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

endpackage

### src/moving_average_warmup.sv
// Boxcar moving average with warm-up.
//
// Input channel: sample_i with sample_valid_i / sample_ready_o. Each accepted
// request is one unsigned sample; only its low SAMPLE_BITS bits are used.
// Output channel: average_q8_o with average_q8_valid_o / average_q8_ready_i.
// Each request gives exactly one result: the mean of the last WINDOW samples
// (fewer during warm-up) in unsigned Q.8, truncated.
//
// A two-entry queue takes requests at the front; the back pops one request,
// reads the ring slot it overwrites, updates the running sum, then runs a
// restoring divider by the fill count, one quotient bit per cycle.
// The back accepts a request in S_IDLE, updates the sum and fill count and
// starts the divider in S_UPD, and in S_DIV waits for the quotient and a
// free output register, then registers the result; only then does it take a
// new request. While the receiver stalls the result holds in its output
// register, the back holds its next finished quotient, and the front queue
// keeps taking requests until full. Reset clears the ring fill count, sum
// and write slot, so the block starts a fresh warm-up.
module moving_average_warmup #(
  parameter int unsigned WINDOW      = mavg_pkg::DefWindow,
  parameter int unsigned SAMPLE_BITS = mavg_pkg::DefSampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic [mavg_pkg::SampleW-1:0] sample_i,
  output logic                         average_q8_valid_o,
  input  logic                         average_q8_ready_i,
  output logic [mavg_pkg::OutW-1:0]    average_q8_o
);
  import mavg_pkg::*;

  localparam int unsigned UW = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;

  logic          q_valid;
  logic          q_ready;
  logic [UW-1:0] q_sample;

  mavg_queue #(
    .W(UW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(sample_valid_i),
    .push_ready_o(sample_ready_o),
    .push_data_i (sample_i[UW-1:0]),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_sample)
  );

  mavg_core #(
    .WINDOW(WINDOW),
    .UW    (UW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_ready_o (q_ready),
    .req_sample_i(q_sample),
    .res_valid_o (average_q8_valid_o),
    .res_ready_i (average_q8_ready_i),
    .res_avg_o   (average_q8_o)
  );

endmodule

### src/mavg_queue.sv
module mavg_queue #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  import mavg_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [W-1:0]    entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store incoming requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### src/mavg_div.sv
module mavg_div #(
  parameter int unsigned DW = 27,
  parameter int unsigned VW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);
  import mavg_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dq_q;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic [VW:0]   trial;
  logic          qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dq_q[DW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
  end

  assign busy_o     = run_q;
  assign quotient_o = dq_q;

  // Shift dividend out and quotient bits in, one per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      dq_q  <= {dq_q[DW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  // Count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(DW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

endmodule

### src/mavg_core.sv
module mavg_core #(
  parameter int unsigned WINDOW = 5,
  parameter int unsigned UW     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic [UW-1:0]            req_sample_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [mavg_pkg::OutW-1:0] res_avg_o
);
  import mavg_pkg::*;

  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW  = UW + CntW;
  localparam int unsigned QW    = SumW + FracBits;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV
  } state_e;

  state_e          state_q;
  logic [UW-1:0]   ring [WINDOW];
  logic [UW-1:0]   old_rd_q;
  logic [UW-1:0]   sample_q;
  logic [SlotW-1:0] slot_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [UW-1:0]   old_val;
  logic            full;
  logic            ring_we;
  logic            div_start;
  logic            div_busy;
  logic [QW-1:0]   quotient;
  logic            res_valid_q;
  logic [OutW-1:0] res_avg_q;
  logic            res_free;

  assign full        = (fill_q == CntW'(WINDOW));
  assign old_val     = full ? old_rd_q : '0;
  assign sum_d       = sum_q - SumW'(old_val) + SumW'(sample_q);
  assign fill_d      = full ? fill_q : fill_q + 1'b1;
  assign ring_we     = (state_q == S_UPD);
  assign div_start   = (state_q == S_UPD);
  assign req_ready_o = (state_q == S_IDLE);
  assign res_free    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_avg_o   = res_avg_q;

  // Sample ring: read the slot about to be overwritten, write the new sample
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[slot_q] <= sample_q;
    end
    old_rd_q <= ring[slot_q];
  end

  // Hold the request sample
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      sample_q <= req_sample_i;
    end
  end

  mavg_div #(
    .DW(QW),
    .VW(CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_d, {FracBits{1'b0}}}),
    .divisor_i (fill_d),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  // Sequence one request: fetch, update, divide, hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
      res_avg_q   <= '0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          sum_q   <= sum_d;
          fill_q  <= fill_d;
          slot_q  <= (slot_q == SlotW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy && res_free) begin
            res_valid_q <= 1'b1;
            res_avg_q   <= OutW'(quotient);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/moving_average_warmup_test.sv
module moving_average_warmup_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mavg_pkg::*;

  localparam int unsigned Window    = DefWindow;
  localparam int unsigned SumW      = 19;
  localparam int unsigned TailWait  = 40;
  localparam int unsigned CycleCap  = 800000;
  localparam int unsigned PhaseSize = 475;

  // Boxcar predictor and store of expected means
  class mean_tracker;
    bit [SampleW-1:0] sample_ring [Window];
    int unsigned      write_slot;
    bit [SumW-1:0]    running_sum;
    int unsigned      fill_level;
    bit [OutW-1:0]    expected_means [$];
    int unsigned      mismatches;

    function new();
      foreach (sample_ring[i]) sample_ring[i] = '0;
      write_slot  = 0;
      running_sum = '0;
      fill_level  = 0;
      mismatches  = 0;
    endfunction

    // Update the window with an accepted request and queue its mean
    function void note_sample(bit [SampleW-1:0] sample);
      bit [31:0] scaled;
      bit [31:0] mean;
      running_sum = running_sum - sample_ring[write_slot] + sample;
      sample_ring[write_slot] = sample;
      write_slot = (write_slot + 1 >= Window) ? 0 : write_slot + 1;
      if (fill_level < Window) begin
        fill_level++;
      end
      scaled = 32'(running_sum) << FracBits;
      mean = scaled / fill_level;
      if (mean > 32'((1 << OutW) - 1)) begin
        mean = 32'((1 << OutW) - 1);
      end
      expected_means.push_back(mean[OutW-1:0]);
    endfunction

    // Compare a delivered mean with the oldest one expected
    function void check_mean(bit [OutW-1:0] actual);
      bit [OutW-1:0] expected;
      if (expected_means.size() == 0) begin
        $error("average_q8: no result expected, actual %0h", actual);
        mismatches++;
      end else begin
        expected = expected_means.pop_front();
        if (actual !== expected) begin
          $error("average_q8: expected %0h, actual %0h", expected, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               sample_valid_i     = 1'b0;
  logic               sample_ready_o;
  logic [SampleW-1:0] sample_i           = '0;
  logic               average_q8_valid_o;
  logic               average_q8_ready_i = 1'b0;
  logic [OutW-1:0]    average_q8_o;

  mean_tracker    window_model = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    cycle_count = 0;
  logic [SampleW-1:0] last_sample = '0;
  logic [SampleW-1:0] directed_samples [$] = '{
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0001, 16'h0002, 16'h0003, 16'h8000, 16'hFFFF, 16'h7FFF,
    16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0000
  };

  moving_average_warmup i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_valid_i     (sample_valid_i),
    .sample_ready_o     (sample_ready_o),
    .sample_i           (sample_i),
    .average_q8_valid_o (average_q8_valid_o),
    .average_q8_ready_i (average_q8_ready_i),
    .average_q8_o       (average_q8_o)
  );

  always #2 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(negedge clk_i) begin
    average_q8_ready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every delivered result
  always @(posedge clk_i) begin
    if (rst_ni && average_q8_valid_o && average_q8_ready_i) begin
      window_model.check_mean(average_q8_o);
    end
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Pick a sample: full range, near zero, near full scale, or a repeat
  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(3))
      0: last_sample = SampleW'($urandom);
      1: last_sample = SampleW'($urandom_range(15));
      2: last_sample = SampleW'(16'hFFFF - $urandom_range(15));
      default: last_sample = last_sample;
    endcase
    return last_sample;
  endfunction

  // Present one request, with random idle cycles first, and hold it until taken
  task automatic send_sample(input logic [SampleW-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i = 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i = 1'b1;
    sample_i = value;
    @(posedge clk_i);
    while (!sample_ready_o) begin
      @(posedge clk_i);
    end
    window_model.note_sample(value);
  endtask

  // Drop valid and wait for every expected mean, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    sample_valid_i = 1'b0;
    while (window_model.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailWait) @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_sample(random_sample());
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Warm-up, full-scale and zero windows, bit patterns
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    drain();

    // Random traffic under different flow control
    run_phase(0, 0, PhaseSize);
    run_phase(78, 0, PhaseSize);
    run_phase(0, 78, PhaseSize / 2);
    run_phase(0, 78, PhaseSize - PhaseSize / 2);
    run_phase(17, 17, PhaseSize);

    if (window_model.mismatches == 0 && window_model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
src/mavg_pkg.sv
src/mavg_queue.sv
src/mavg_div.sv
src/mavg_core.sv
src/moving_average_warmup.sv
sim/moving_average_warmup_test.sv
